### sv/mns_pkg.sv
// shared types and constants for the melody note sequencer
// no dependencies; imported by mns_note_mem and melody_note_sequencer_unit
`default_nettype none

package mns_pkg;

    localparam int KIND_W = 2;
    localparam int MEL_W  = 2;
    localparam int LEN_W  = 7;
    localparam int FREQ_W = 16;
    localparam int DUR_W  = 16;
    localparam int ADDR_W = 6;
    localparam int NOTE_W = FREQ_W + DUR_W;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEN0   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN1   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN2   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd3;

    localparam logic [MEL_W-1:0]  MEL_NONE   = 2'd3;
    localparam logic [FREQ_W-1:0] THRESH_RST = 16'd100;

    typedef struct packed {
        logic              tone_on;
        logic [FREQ_W-1:0] tone_freq;
        logic [MEL_W-1:0]  melody;
    } res_t;

endpackage

`default_nettype wire

### sv/mns_note_mem.sv
// note store: single write port, single registered read port
// depends on mns_pkg for the note word width
`default_nettype none

module mns_note_mem #(
    parameter int DEPTH = 192,
    parameter int AW    = 8
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [mns_pkg::NOTE_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [mns_pkg::NOTE_W-1:0] rd_data
);
    import mns_pkg::*;

    logic [NOTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/melody_note_sequencer_unit.sv
// Melody note sequencer. Accepts one request per clock while in_ready is high
// (tick, play, stop or note write) and returns exactly one result per request:
// tone on/off, the sounding frequency and the melody now playing. Notes sit in
// a synchronous note memory of NUM_MELODIES x MAX_NOTES words; a request that
// starts a new note issues a one-cycle read, and the fetched duration and
// frequency are forwarded from the read port to the request behind it, so
// requests flow at one per cycle unless the result queue is full. A result is
// registered in res_pend and then in a three-entry result queue before it
// reaches the output, so input is taken while results wait. The note store has
// no reset and no clearing pass: a note must be written before its melody
// reaches it. Configuration writes are taken at any time (cfg_ready is always
// high) but belong to idle periods. Depends on mns_pkg and mns_note_mem.
`default_nettype none

module melody_note_sequencer_unit #(
    parameter int NUM_MELODIES = 3,
    parameter int MAX_NOTES    = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mns_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [mns_pkg::CFG_W-1:0]     cfg_data,
    // requests
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mns_pkg::KIND_W-1:0]    kind,
    input  wire logic [mns_pkg::MEL_W-1:0]     melody_id,
    input  wire logic                          loop_flag,
    input  wire logic [mns_pkg::ADDR_W-1:0]    note_addr,
    input  wire logic [mns_pkg::FREQ_W-1:0]    note_freq,
    input  wire logic [mns_pkg::DUR_W-1:0]     note_dur,
    // results
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               tone_on,
    output logic [mns_pkg::FREQ_W-1:0]         tone_freq,
    output logic [mns_pkg::MEL_W-1:0]          current_melody
);
    import mns_pkg::*;

    localparam int DEPTH  = NUM_MELODIES * MAX_NOTES;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CNT_W  = $clog2(MAX_NOTES + 1);
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int QDEPTH = 3;
    localparam int QP_W   = 2;

    // configuration registers
    logic [LEN_W-1:0]  len0_reg, len1_reg, len2_reg;
    logic [FREQ_W-1:0] thr_reg;

    // playback state
    logic [MEL_W-1:0]  mel_reg, mel_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rpt_reg, rpt_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic              on_reg, on_next;
    logic              ld_pend_reg, ld_pend_next;
    logic              res_pend_reg;

    // values after any pending note fetch
    logic [DUR_W-1:0]  rem_cur;
    logic [FREQ_W-1:0] freq_cur;
    logic              on_cur;

    logic [NOTE_W-1:0] rd_data;
    logic [FREQ_W-1:0] rd_freq;
    logic              rd_silent;

    logic              in_fire;
    logic              id_ok, addr_ok;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [MEL_W-1:0]  rd_mel;
    logic [IDX_W-1:0]  rd_idx;

    // result queue
    res_t              q_mem [QDEPTH];
    logic [QP_W-1:0]   q_wp_reg, q_rp_reg;
    logic [QP_W-1:0]   q_cnt_reg;
    logic              q_push, q_pop;
    res_t              res_cur;
    res_t              q_head;

    function automatic logic [CMP_W-1:0] len_sat(
        input logic [MEL_W-1:0] m,
        input logic [LEN_W-1:0] l0,
        input logic [LEN_W-1:0] l1,
        input logic [LEN_W-1:0] l2
    );
        logic [CMP_W-1:0] l;
        l = '0;
        case (m)
            2'd0:    l = CMP_W'(l0);
            2'd1:    l = CMP_W'(l1);
            2'd2:    l = CMP_W'(l2);
            default: l = '0;
        endcase
        if (CMP_W'(m) >= CMP_W'(NUM_MELODIES))
        begin
            l = '0;
        end
        if (l > CMP_W'(MAX_NOTES))
        begin
            l = CMP_W'(MAX_NOTES);
        end
        return l;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = ({1'b0, q_cnt_reg} + {2'b00, res_pend_reg}) <= 3'd2;
    assign in_fire   = in_valid && in_ready;

    // forward fetched note into the working state
    assign rd_freq   = rd_data[FREQ_W-1:0];
    assign rd_silent = rd_freq < thr_reg;
    assign rem_cur   = ld_pend_reg ? rd_data[NOTE_W-1:FREQ_W] : rem_reg;
    assign freq_cur  = ld_pend_reg ? (rd_silent ? '0 : rd_freq) : freq_reg;
    assign on_cur    = ld_pend_reg ? !rd_silent : on_reg;

    assign id_ok   = melody_id < MEL_W'(NUM_MELODIES);
    assign addr_ok = CMP_W'(note_addr) < CMP_W'(MAX_NOTES);
    assign wr_addr = AW'(32'(melody_id) * 32'(MAX_NOTES) + 32'(note_addr));
    assign rd_addr = AW'(32'(rd_mel) * 32'(MAX_NOTES) + 32'(rd_idx));

    always_comb
    begin
        logic             sn_req;
        logic             halt;
        logic [MEL_W-1:0] sn_mel;
        logic [CNT_W-1:0] sn_idx;
        logic             sn_rpt;
        logic [CMP_W-1:0] len;
        logic             at_end;
        logic [CNT_W-1:0] idx0;

        mel_next  = mel_reg;
        idx_next  = idx_reg;
        rpt_next  = rpt_reg;
        rem_next  = rem_cur;
        freq_next = freq_cur;
        on_next   = on_cur;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_mel    = mel_reg;
        rd_idx    = '0;
        sn_req    = 1'b0;
        halt      = 1'b0;
        sn_mel    = mel_reg;
        sn_idx    = idx_reg;
        sn_rpt    = rpt_reg;
        len       = '0;
        at_end    = 1'b0;
        idx0      = '0;

        if (in_fire)
        begin
            case (kind)
                KIND_TICK:
                begin
                    if (mel_reg != MEL_NONE)
                    begin
                        if (rem_cur == '0)
                        begin
                            sn_req = 1'b1;
                        end
                        else
                        begin
                            rem_next = rem_cur - 1'b1;
                            sn_req   = (rem_cur == DUR_W'(1));
                        end
                    end
                end
                KIND_PLAY:
                begin
                    if (!id_ok)
                    begin
                        halt = 1'b1;
                    end
                    else if (mel_reg != melody_id)
                    begin
                        mel_next = melody_id;
                        rpt_next = loop_flag;
                        sn_mel   = melody_id;
                        sn_idx   = '0;
                        sn_rpt   = loop_flag;
                        sn_req   = 1'b1;
                    end
                end
                KIND_STOP:
                begin
                    halt = 1'b1;
                end
                default:
                begin
                    wr_en = id_ok && addr_ok;
                end
            endcase
        end

        // start the next note, wrapping or stopping at the end of the melody
        if (sn_req)
        begin
            len    = len_sat(sn_mel, len0_reg, len1_reg, len2_reg);
            at_end = CMP_W'(sn_idx) >= len;
            if (len == '0 || (at_end && !sn_rpt))
            begin
                halt = 1'b1;
            end
            else
            begin
                idx0     = at_end ? '0 : sn_idx;
                rd_en    = 1'b1;
                rd_mel   = sn_mel;
                rd_idx   = idx0[IDX_W-1:0];
                idx_next = idx0 + 1'b1;
            end
        end

        if (halt)
        begin
            mel_next  = MEL_NONE;
            idx_next  = '0;
            rem_next  = '0;
            freq_next = '0;
            on_next   = 1'b0;
        end

        ld_pend_next = rd_en;
    end

    mns_note_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_note_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({note_dur, note_freq}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len0_reg <= '0;
            len1_reg <= '0;
            len2_reg <= '0;
            thr_reg  <= THRESH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_LEN0:   len0_reg <= cfg_data[LEN_W-1:0];
                REG_LEN1:   len1_reg <= cfg_data[LEN_W-1:0];
                REG_LEN2:   len2_reg <= cfg_data[LEN_W-1:0];
                REG_THRESH: thr_reg  <= cfg_data[FREQ_W-1:0];
                default:    thr_reg  <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mel_reg      <= MEL_NONE;
            idx_reg      <= '0;
            rpt_reg      <= 1'b0;
            rem_reg      <= '0;
            freq_reg     <= '0;
            on_reg       <= 1'b0;
            ld_pend_reg  <= 1'b0;
            res_pend_reg <= 1'b0;
        end
        else
        begin
            mel_reg      <= mel_next;
            idx_reg      <= idx_next;
            rpt_reg      <= rpt_next;
            rem_reg      <= rem_next;
            freq_reg     <= freq_next;
            on_reg       <= on_next;
            ld_pend_reg  <= ld_pend_next;
            res_pend_reg <= in_fire;
        end
    end

    // the cycle after a request, the working state is that request's result
    assign res_cur.tone_on   = on_cur;
    assign res_cur.tone_freq = on_cur ? freq_cur : '0;
    assign res_cur.melody    = mel_reg;

    assign q_push = res_pend_reg;
    assign q_pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[q_wp_reg] <= res_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= '0;
            q_rp_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
            begin
                q_wp_reg <= (q_wp_reg == QP_W'(QDEPTH - 1)) ? '0 : q_wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                q_rp_reg <= (q_rp_reg == QP_W'(QDEPTH - 1)) ? '0 : q_rp_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + QP_W'(q_push) - QP_W'(q_pop);
        end
    end

    assign q_head         = q_mem[q_rp_reg];
    assign out_valid      = q_cnt_reg != '0;
    assign tone_on        = q_head.tone_on;
    assign tone_freq      = q_head.tone_freq;
    assign current_melody = q_head.melody;

endmodule

`default_nettype wire
